// ===== sv/mtds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtds_pkg
// Shared types, constants and calendar helpers for the daily spreader.
// ----------------------------------------------------------------------------
package mtds_pkg;

    localparam int MONTHS      = 12;
    localparam int TOTAL_W     = 32;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int REQ_W       = 2;
    localparam int DIV_STEPS   = TOTAL_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  RESET_YEAR = YEAR_W'(2000);
    localparam logic [MONTH_W-1:0] LAST_MONTH = MONTH_W'(MONTHS);

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit year
    localparam int HUND_RECIP = 5243;
    localparam int HUND_SHIFT = 19;
    localparam int HUND_PROD_W = YEAR_W + 13;
    localparam int HUND_W = HUND_PROD_W - HUND_SHIFT;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SET,
        OP_STEP
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [MONTH_W-1:0]         month_index;
        logic signed [TOTAL_W-1:0]  month_total;
        logic [YEAR_W-1:0]          set_year;
        logic [MONTH_W-1:0]         set_month;
        logic [DAY_W-1:0]           set_day;
    } item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LEAP,
        B_CHECK,
        B_DIV,
        B_OUT
    } back_state_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m) inside
                4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
                4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
                default:                 len = DAY_W'(31);
            endcase
            return len;
        end
    endfunction

endpackage

// ===== sv/mtds_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtds_front
// Accepts request transfers, drops unused codes and bad load months, and
// queues the rest in order for the back end.
// ----------------------------------------------------------------------------
module mtds_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mtds_pkg::REQ_W-1:0]           s_req_type,
    input  logic [mtds_pkg::MONTH_W-1:0]         s_month_index,
    input  logic signed [mtds_pkg::TOTAL_W-1:0]  s_month_total,
    input  logic [mtds_pkg::YEAR_W-1:0]          s_set_year,
    input  logic [mtds_pkg::MONTH_W-1:0]         s_set_month,
    input  logic [mtds_pkg::DAY_W-1:0]           s_set_day,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output mtds_pkg::item_t                      q_item
);

    mtds_pkg::item_t entry_mem [mtds_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            keep;
    logic            push;
    logic            pop;
    mtds_pkg::item_t in_item;

    always_comb begin
        in_item.month_index = s_month_index;
        in_item.month_total = s_month_total;
        in_item.set_year    = s_set_year;
        in_item.set_month   = s_set_month;
        in_item.set_day     = s_set_day;
        in_item.op          = mtds_pkg::OP_LOAD;
        keep                = 1'b0;
        unique case (s_req_type)
            mtds_pkg::REQ_LOAD: begin
                in_item.op = mtds_pkg::OP_LOAD;
                keep = (s_month_index != '0) && (s_month_index <= mtds_pkg::LAST_MONTH);
            end
            mtds_pkg::REQ_SET: begin
                in_item.op = mtds_pkg::OP_SET;
                keep = 1'b1;
            end
            mtds_pkg::REQ_STEP: begin
                in_item.op = mtds_pkg::OP_STEP;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (count_reg != 2'(mtds_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = entry_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ===== sv/mtds_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtds_div
// Bit-serial signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mtds_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [mtds_pkg::TOTAL_W-1:0]  dividend,
    input  logic [mtds_pkg::DAY_W-1:0]           divisor,
    output logic                                 done,
    output logic signed [mtds_pkg::TOTAL_W-1:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [mtds_pkg::DAY_W-1:0]    cnt_reg;
    logic [mtds_pkg::DAY_W-1:0]    rem_reg;
    logic [mtds_pkg::DAY_W-1:0]    dsr_reg;
    logic [mtds_pkg::TOTAL_W-1:0]  quo_reg;
    logic                          neg_reg;
    logic [mtds_pkg::DAY_W:0]      trial;
    logic [mtds_pkg::DAY_W:0]      diff;
    logic                          ge;
    logic [mtds_pkg::TOTAL_W-1:0]  mag;

    assign mag   = dividend[mtds_pkg::TOTAL_W-1] ? (-dividend) : dividend;
    assign trial = {rem_reg, quo_reg[mtds_pkg::TOTAL_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= mag;
            dsr_reg <= divisor;
            neg_reg <= dividend[mtds_pkg::TOTAL_W-1];
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[mtds_pkg::DAY_W-1:0] : trial[mtds_pkg::DAY_W-1:0];
            quo_reg <= {quo_reg[mtds_pkg::TOTAL_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mtds_pkg::DAY_W'(mtds_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/mtds_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtds_back
// Executes queued requests: table loads, date sets and day steps with
// calendar check, date advance and daily share division.
// ----------------------------------------------------------------------------
module mtds_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  mtds_pkg::item_t                      q_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mtds_pkg::TOTAL_W-1:0]  m_daily_value,
    output logic [mtds_pkg::YEAR_W-1:0]          m_out_year,
    output logic [mtds_pkg::MONTH_W-1:0]         m_out_month,
    output logic [mtds_pkg::DAY_W-1:0]           m_out_day,
    output logic                                 m_date_error
);

    mtds_pkg::back_state_t state_reg;
    mtds_pkg::back_state_t state_next;

    logic signed [mtds_pkg::TOTAL_W-1:0] table_mem [mtds_pkg::MONTHS];
    logic signed [mtds_pkg::TOTAL_W-1:0] total_reg;
    logic [mtds_pkg::YEAR_W-1:0]         cur_year_reg;
    logic [mtds_pkg::MONTH_W-1:0]        cur_month_reg;
    logic [mtds_pkg::DAY_W-1:0]          cur_day_reg;
    logic [mtds_pkg::HUND_W-1:0]         hund_reg;
    logic signed [mtds_pkg::TOTAL_W-1:0] daily_reg;
    logic [mtds_pkg::YEAR_W-1:0]         out_year_reg;
    logic [mtds_pkg::MONTH_W-1:0]        out_month_reg;
    logic [mtds_pkg::DAY_W-1:0]          out_day_reg;
    logic                                err_reg;

    logic [mtds_pkg::HUND_PROD_W-1:0]    hund_prod;
    logic [mtds_pkg::YEAR_W:0]           rem100;
    logic                                leap;
    logic [mtds_pkg::DAY_W-1:0]          days;
    logic                                month_ok;
    logic                                date_ok;
    logic                                ovf;
    logic [mtds_pkg::YEAR_W-1:0]         ny;
    logic [mtds_pkg::MONTH_W-1:0]        nm;
    logic [mtds_pkg::DAY_W-1:0]          nd;
    logic                                div_start;
    logic                                div_done;
    logic signed [mtds_pkg::TOTAL_W-1:0] div_q;

    assign hund_prod = mtds_pkg::HUND_PROD_W'(cur_year_reg)
                     * mtds_pkg::HUND_PROD_W'(mtds_pkg::HUND_RECIP);
    assign rem100    = {1'b0, cur_year_reg}
                     - (mtds_pkg::YEAR_W+1)'(hund_reg) * (mtds_pkg::YEAR_W+1)'(100);
    assign leap      = (cur_year_reg[1:0] == 2'b00)
                     && ((rem100 != '0) || (hund_reg[1:0] == 2'b00));
    assign days      = mtds_pkg::month_len(cur_month_reg, leap);
    assign month_ok  = (cur_month_reg != '0) && (cur_month_reg <= mtds_pkg::LAST_MONTH);

    always_comb begin
        ny  = cur_year_reg;
        nm  = cur_month_reg;
        nd  = cur_day_reg + 1'b1;
        ovf = 1'b0;
        if (cur_day_reg == days) begin
            nd = mtds_pkg::DAY_W'(1);
            if (cur_month_reg == mtds_pkg::LAST_MONTH) begin
                nm  = mtds_pkg::MONTH_W'(1);
                ny  = cur_year_reg + 1'b1;
                ovf = (cur_year_reg == mtds_pkg::MAX_YEAR);
            end else begin
                nm = cur_month_reg + 1'b1;
            end
        end
        date_ok = (cur_year_reg != '0) && (cur_year_reg <= mtds_pkg::MAX_YEAR)
               && month_ok && (cur_day_reg != '0) && (cur_day_reg <= days) && !ovf;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mtds_pkg::B_IDLE: begin
                if (q_valid && (q_item.op == mtds_pkg::OP_STEP)) begin
                    state_next = mtds_pkg::B_LEAP;
                end
            end
            mtds_pkg::B_LEAP:  state_next = mtds_pkg::B_CHECK;
            mtds_pkg::B_CHECK: state_next = date_ok ? mtds_pkg::B_DIV : mtds_pkg::B_OUT;
            mtds_pkg::B_DIV: begin
                if (div_done) begin
                    state_next = mtds_pkg::B_OUT;
                end
            end
            mtds_pkg::B_OUT: begin
                if (m_ready) begin
                    state_next = mtds_pkg::B_IDLE;
                end
            end
            default: state_next = mtds_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_ready   = (state_reg == mtds_pkg::B_IDLE);
        m_valid   = (state_reg == mtds_pkg::B_OUT);
        div_start = (state_reg == mtds_pkg::B_CHECK) && date_ok;
    end

    assign m_daily_value = daily_reg;
    assign m_out_year    = out_year_reg;
    assign m_out_month   = out_month_reg;
    assign m_out_day     = out_day_reg;
    assign m_date_error  = err_reg;

    // month table: written on load, read at most once per step
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && (q_item.op == mtds_pkg::OP_LOAD)) begin
            table_mem[mtds_pkg::MONTH_W'(q_item.month_index - 1'b1)] <= q_item.month_total;
        end
        if ((state_reg == mtds_pkg::B_LEAP) && month_ok) begin
            total_reg <= table_mem[mtds_pkg::MONTH_W'(cur_month_reg - 1'b1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mtds_pkg::B_LEAP) begin
            hund_reg <= hund_prod[mtds_pkg::HUND_PROD_W-1:mtds_pkg::HUND_SHIFT];
        end
        if (state_reg == mtds_pkg::B_CHECK) begin
            out_year_reg  <= cur_year_reg;
            out_month_reg <= cur_month_reg;
            out_day_reg   <= cur_day_reg;
            err_reg       <= !date_ok;
            daily_reg     <= '0;
        end
        if ((state_reg == mtds_pkg::B_DIV) && div_done) begin
            daily_reg <= div_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mtds_pkg::B_IDLE;
            cur_year_reg  <= mtds_pkg::RESET_YEAR;
            cur_month_reg <= mtds_pkg::MONTH_W'(1);
            cur_day_reg   <= mtds_pkg::DAY_W'(1);
        end else begin
            state_reg <= state_next;
            if (q_valid && q_ready && (q_item.op == mtds_pkg::OP_SET)) begin
                cur_year_reg  <= q_item.set_year;
                cur_month_reg <= q_item.set_month;
                cur_day_reg   <= q_item.set_day;
            end
            if (div_start) begin
                cur_year_reg  <= ny;
                cur_month_reg <= nm;
                cur_day_reg   <= nd;
            end
        end
    end

    mtds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (days),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

// ===== sv/monthly_total_daily_spreader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monthly_total_daily_spreader_unit
// Month total table and Gregorian date; each step emits the daily share.
// Sequence: a step leaves the queue, then passes the leap check, date check,
//   serial divide (skipped for a bad date) and output.
// The back end takes no request while a step is in progress; loads and
//   sets apply as they leave the queue; a 2-entry queue decouples the input.
// Reset: date returns to 2000-01-01, queue and output empty; the month
//   table is not cleared.
// ----------------------------------------------------------------------------
module monthly_total_daily_spreader_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mtds_pkg::REQ_W-1:0]           s_req_type,
    input  logic [mtds_pkg::MONTH_W-1:0]         s_month_index,
    input  logic signed [mtds_pkg::TOTAL_W-1:0]  s_month_total,
    input  logic [mtds_pkg::YEAR_W-1:0]          s_set_year,
    input  logic [mtds_pkg::MONTH_W-1:0]         s_set_month,
    input  logic [mtds_pkg::DAY_W-1:0]           s_set_day,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mtds_pkg::TOTAL_W-1:0]  m_daily_value,
    output logic [mtds_pkg::YEAR_W-1:0]          m_out_year,
    output logic [mtds_pkg::MONTH_W-1:0]         m_out_month,
    output logic [mtds_pkg::DAY_W-1:0]           m_out_day,
    output logic                                 m_date_error
);

    logic            q_valid;
    logic            q_ready;
    mtds_pkg::item_t q_item;

    mtds_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_month_index (s_month_index),
        .s_month_total (s_month_total),
        .s_set_year    (s_set_year),
        .s_set_month   (s_set_month),
        .s_set_day     (s_set_day),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    mtds_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_daily_value (m_daily_value),
        .m_out_year    (m_out_year),
        .m_out_month   (m_out_month),
        .m_out_day     (m_out_day),
        .m_date_error  (m_date_error)
    );

endmodule

// ===== dv/tb_monthly_total_daily_spreader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_monthly_total_daily_spreader_unit
// Self-checking bench for the daily spreader. A clocked driver feeds requests
// from a pending queue, and an in-bench calendar and month-total table
// predict each step's daily share and date. A clocked monitor checks every
// result transfer in order. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_monthly_total_daily_spreader_unit;

    import mtds_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic [MONTH_W-1:0]        midx;
        logic signed [TOTAL_W-1:0] total;
        logic [YEAR_W-1:0]         yr;
        logic [MONTH_W-1:0]        mo;
        logic [DAY_W-1:0]          dy;
    } spread_req_t;

    typedef struct {
        logic signed [TOTAL_W-1:0] value;
        logic [YEAR_W-1:0]         yr;
        logic [MONTH_W-1:0]        mo;
        logic [DAY_W-1:0]          dy;
        logic                      err;
    } daily_share_t;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic [REQ_W-1:0]             s_req_type    = '0;
    logic [MONTH_W-1:0]           s_month_index = '0;
    logic signed [TOTAL_W-1:0]    s_month_total = '0;
    logic [YEAR_W-1:0]            s_set_year    = '0;
    logic [MONTH_W-1:0]           s_set_month   = '0;
    logic [DAY_W-1:0]             s_set_day     = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic signed [TOTAL_W-1:0]    m_daily_value;
    logic [YEAR_W-1:0]            m_out_year;
    logic [MONTH_W-1:0]           m_out_month;
    logic [DAY_W-1:0]             m_out_day;
    logic                         m_date_error;

    // in-bench copy of the block's state
    logic signed [TOTAL_W-1:0]    month_totals [MONTHS];
    logic [YEAR_W-1:0]            date_year  = RESET_YEAR;
    logic [MONTH_W-1:0]           date_month = MONTH_W'(1);
    logic [DAY_W-1:0]             date_day   = DAY_W'(1);

    spread_req_t  pending_req_q[$];
    daily_share_t expected_share_q[$];
    spread_req_t  in_flight;

    int  gap_left        = 0;
    int  stall_left      = 0;
    bit  steady_in       = 1'b0;
    bit  steady_out      = 1'b0;
    int  idle_cycles     = 0;
    int  mismatch_count  = 0;
    int  requests_taken  = 0;
    int  results_checked = 0;
    int  n_loads = 0, n_sets = 0, n_steps = 0, n_ignored = 0;
    int  n_date_errors = 0, n_year_rolls = 0, n_leap_days = 0;

    monthly_total_daily_spreader_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_month_index (s_month_index),
        .s_month_total (s_month_total),
        .s_set_year    (s_set_year),
        .s_set_month   (s_set_month),
        .s_set_day     (s_set_day),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_daily_value (m_daily_value),
        .m_out_year    (m_out_year),
        .m_out_month   (m_out_month),
        .m_out_day     (m_out_day),
        .m_date_error  (m_date_error)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Calendar and daily-share prediction
    // ------------------------------------------------------------------
    function automatic bit is_leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
        if (y < 1 || y > int'(MAX_YEAR))
            return 1'b0;
        if (m < 1 || m > MONTHS)
            return 1'b0;
        return d >= 1 && d <= days_in_month(y, m);
    endfunction

    task automatic apply_request(input spread_req_t rq);
        daily_share_t want;
        int unsigned  days, ny, nm, nd;
        int           tot;
        case (rq.req)
            REQ_LOAD: begin
                if (rq.midx >= 1 && rq.midx <= MONTHS) begin
                    month_totals[rq.midx - 1] = rq.total;
                    n_loads++;
                end else begin
                    n_ignored++;
                end
            end
            REQ_SET: begin
                date_year  = rq.yr;
                date_month = rq.mo;
                date_day   = rq.dy;
                n_sets++;
            end
            REQ_STEP: begin
                n_steps++;
                want.value = '0;
                want.yr    = date_year;
                want.mo    = date_month;
                want.dy    = date_day;
                want.err   = 1'b1;
                if (date_valid(date_year, date_month, date_day)) begin
                    days = days_in_month(date_year, date_month);
                    ny   = date_year;
                    nm   = date_month;
                    nd   = date_day + 1;
                    if (nd > days) begin
                        nd = 1;
                        nm = date_month + 1;
                        if (nm > MONTHS) begin
                            nm = 1;
                            ny = date_year + 1;
                        end
                    end
                    if (ny <= int'(MAX_YEAR)) begin
                        tot        = month_totals[date_month - 1];
                        want.value = tot / int'(days);
                        want.err   = 1'b0;
                        if (date_month == 2 && date_day == 29)
                            n_leap_days++;
                        if (ny != date_year)
                            n_year_rolls++;
                        date_year  = YEAR_W'(ny);
                        date_month = MONTH_W'(nm);
                        date_day   = DAY_W'(nd);
                    end
                end
                if (want.err)
                    n_date_errors++;
                expected_share_q.push_back(want);
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic spread_req_t random_req(logic [REQ_W-1:0] req);
        spread_req_t rq;
        rq.req   = req;
        rq.midx  = MONTH_W'($urandom);
        rq.total = $urandom;
        rq.yr    = YEAR_W'($urandom);
        rq.mo    = MONTH_W'($urandom);
        rq.dy    = DAY_W'($urandom);
        return rq;
    endfunction

    function automatic logic signed [TOTAL_W-1:0] pick_total();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            4:       return $signed(32'($urandom_range(0, 200))) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_load(input int unsigned idx, input logic signed [TOTAL_W-1:0] total);
        spread_req_t rq;
        rq       = random_req(REQ_LOAD);
        rq.midx  = MONTH_W'(idx);
        rq.total = total;
        pending_req_q.push_back(rq);
    endtask

    task automatic queue_set(input int unsigned y, input int unsigned m, input int unsigned d);
        spread_req_t rq;
        rq    = random_req(REQ_SET);
        rq.yr = YEAR_W'(y);
        rq.mo = MONTH_W'(m);
        rq.dy = DAY_W'(d);
        pending_req_q.push_back(rq);
    endtask

    task automatic queue_steps(input int n);
        repeat (n) pending_req_q.push_back(random_req(REQ_STEP));
    endtask

    task automatic pick_date(output int unsigned y, output int unsigned m,
                             output int unsigned d);
        y = $urandom_range(1, int'(MAX_YEAR));
        m = $urandom_range(1, MONTHS);
        case ($urandom_range(0, 5))
            0: d = $urandom_range(1, days_in_month(y, m));
            1: d = days_in_month(y, m) - $urandom_range(0, 2);
            2: begin
                m = MONTHS;
                d = $urandom_range(28, 31);
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: y = 1900;
                    1: y = 2000;
                    2: y = 2100;
                    3: y = 4 * $urandom_range(1, 2499);
                    default: ;
                endcase
                m = 2;
                d = $urandom_range(27, days_in_month(y, 2));
            end
            4: begin
                y = int'(MAX_YEAR) - $urandom_range(0, 1);
                m = MONTHS;
                d = $urandom_range(20, 31);
            end
            default: begin
                y = 1;
                m = 1;
                d = $urandom_range(1, 3);
            end
        endcase
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic check_result();
        daily_share_t want;
        if (expected_share_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d-%0d-%0d value %0d err %0b",
                                      m_out_year, m_out_month, m_out_day,
                                      m_daily_value, m_date_error));
            return;
        end
        want = expected_share_q.pop_front();
        results_checked++;
        if (m_daily_value !== want.value)
            report_mismatch($sformatf("daily_value got %0d want %0d on %0d-%0d-%0d",
                                      m_daily_value, want.value, want.yr, want.mo, want.dy));
        if (m_out_year !== want.yr)
            report_mismatch($sformatf("out_year got %0d want %0d", m_out_year, want.yr));
        if (m_out_month !== want.mo)
            report_mismatch($sformatf("out_month got %0d want %0d", m_out_month, want.mo));
        if (m_out_day !== want.dy)
            report_mismatch($sformatf("out_day got %0d want %0d", m_out_day, want.dy));
        if (m_date_error !== want.err)
            report_mismatch($sformatf("date_error got %0b want %0b on %0d-%0d-%0d",
                                      m_date_error, want.err, want.yr, want.mo, want.dy));
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(in_flight);
                requests_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_req_q.size() > 0) begin
                    in_flight = pending_req_q.pop_front();
                    s_req_type    <= in_flight.req;
                    s_month_index <= in_flight.midx;
                    s_month_total <= in_flight.total;
                    s_set_year    <= in_flight.yr;
                    s_set_month   <= in_flight.mo;
                    s_set_day     <= in_flight.dy;
                    s_valid       <= 1'b1;
                    if ($urandom_range(0, 199) == 0)
                        steady_in = !steady_in;
                    gap_left = steady_in ? 0 : draw_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            if ($urandom_range(0, 299) == 0)
                steady_out = !steady_out;
            if (stall_left == 0 && !steady_out && $urandom_range(0, 99) < 25)
                stall_left = draw_gap();
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_share_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          counted;
        int          n;
        int unsigned y, m, d;

        // directed: table preload with extreme totals, then calendar corners
        queue_load(1, 32'sh7FFF_FFFF);
        queue_load(2, 32'sh8000_0000);
        queue_load(3, 32'shFFFF_FFFF);
        queue_load(4, 32'sh0000_0001);
        queue_load(5, 32'sh0000_0000);
        for (int i = 6; i <= MONTHS; i++)
            queue_load(i, pick_total());
        queue_steps(1);                     // reset date, largest total
        queue_set(2000, 2, 28);             // leap century, most negative total
        queue_steps(3);
        queue_set(1900, 2, 28);             // century that is not leap
        queue_steps(1);
        queue_set(int'(MAX_YEAR), 12, 31);  // last representable day
        queue_steps(1);
        queue_set(2023, 2, 29);             // day past end of February
        queue_steps(1);
        queue_load(0, 32'sh1234_5678);      // month index out of range
        queue_load(15, 32'sh7654_3210);
        pending_req_q.push_back(random_req(REQ_UNUSED));

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    pick_date(y, m, d);
                    queue_set(y, m, d);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 9) == 0)
                            queue_load($urandom_range(1, MONTHS), pick_total());
                        else
                            queue_steps(1);
                    end
                    counted += n + 1;
                end
                11, 12, 13: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        queue_load($urandom_range(1, MONTHS), pick_total());
                    counted += n;
                end
                14, 15, 16: begin
                    n = $urandom_range(1, 12);
                    queue_steps(n);
                    counted += n;
                end
                17: begin
                    // bad or arbitrary date, stored as given
                    case ($urandom_range(0, 5))
                        0: queue_set(0, $urandom_range(1, 12), $urandom_range(1, 28));
                        1: queue_set($urandom_range(int'(MAX_YEAR) + 1, 16383), 1, 1);
                        2: queue_set(2024, $urandom_range(0, 1) ? 0 : $urandom_range(13, 15), 5);
                        3: queue_set(1999, $urandom_range(1, 12), 0);
                        4: queue_set(2021, 4 + 2 * $urandom_range(0, 1), 31);
                        default: queue_set($urandom, $urandom, $urandom);
                    endcase
                    queue_steps($urandom_range(1, 2));
                    counted += 2;
                end
                18: begin
                    // ignored requests
                    if ($urandom_range(0, 1))
                        queue_load($urandom_range(0, 1) ? 0 : $urandom_range(13, 15),
                                   pick_total());
                    else
                        pending_req_q.push_back(random_req(REQ_UNUSED));
                end
                default: begin
                    // broken sequence: set, unused code, then step
                    pick_date(y, m, d);
                    queue_set(y, m, d);
                    pending_req_q.push_back(random_req(REQ_UNUSED));
                    queue_steps(1);
                    counted += 2;
                end
            endcase
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_req_q.size() > 0 || s_valid)
            @(posedge aclk);
        while (expected_share_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Requests: %0d taken (%0d loads, %0d sets, %0d steps, %0d ignored)",
                 requests_taken, n_loads, n_sets, n_steps, n_ignored);
        $display("Results: %0d checked, %0d bad dates, %0d year rollovers, %0d leap days",
                 results_checked, n_date_errors, n_year_rolls, n_leap_days);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
